// File: src/dq_pkg.sv
// Package for the double-ended queue: opcodes, cell commands and sizing defaults.
package dq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    // Field widths fixed by the interface
    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;

    // Item opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_NTH        = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    // Per-cell command
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHIFT = 2'd1,  // take the neighbor toward the front (push front)
        CELL_PULL  = 2'd2,  // take the neighbor toward the back (pop front)
        CELL_LOAD  = 2'd3   // take the pushed word (push back)
    } cell_cmd_t;

endpackage

// File: src/double_ended_queue.sv
// Top level of the double-ended queue: control, cell chain and result register.
//
//  Channel  | Direction | Ports                                        | Transfer
//  ---------+-----------+----------------------------------------------+-------------------
//  input    | in        | s_opcode, s_payload_in, s_position           | s_valid && s_ready
//  result   | out       | m_payload_out, m_valid_res, m_overflow       | m_valid && m_ready
//
//  Each operation executes on the input transfer and its result is in the output register
//  on the next cycle. One operation per cycle is sustained while m_ready stays high; the
//  limit is the single shift of the cell chain and the one read mux per operation.
//  Reset (aresetn low, synchronous) empties the queue and clears the output valid flag;
//  entry contents are not cleared. A stalled result holds the input side only when the
//  output register is full and m_ready is low.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF,
    parameter int WIDTH = dq_pkg::WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dq_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [dq_pkg::DATA_W-1:0]     s_payload_in,
    input  logic [dq_pkg::POS_W-1:0]      s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dq_pkg::DATA_W-1:0]     m_payload_out,
    output logic                          m_valid_res,
    output logic                          m_overflow
);
    import dq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] payload_reg;
    logic [DATA_W-1:0] payload_next;
    logic              valid_res_reg;
    logic              valid_res_next;
    logic              overflow_reg;
    logic              overflow_next;

    logic              accept;
    logic              full;
    logic              empty;
    op_t               op;
    logic [WIDTH-1:0]  word;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  back_idx;
    logic [IDX_W-1:0]  load_idx;
    logic [WIDTH-1:0]  rd_data;

    cell_cmd_t         cell_cmd  [DEPTH];
    logic [WIDTH-1:0]  cell_data [DEPTH];

    assign accept   = s_valid && s_ready;
    assign s_ready  = !out_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign op       = op_t'(s_opcode);
    assign word     = WIDTH'(s_payload_in);
    assign pos_ext  = CMP_W'(s_position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign back_idx = IDX_W'(count_reg - CNT_W'(1));
    assign load_idx = IDX_W'(count_reg);

    // Single read port of the chain: back entry or the requested position
    always_comb begin
        priority case (op)
            OP_POP_BACK, OP_PEEK_BACK: rd_idx = back_idx;
            OP_NTH:                    rd_idx = pos_ext[IDX_W-1:0];
            default:                   rd_idx = '0;
        endcase
    end

    assign rd_data = cell_data[rd_idx];

    // Operation decode: cell commands, count update, result fields
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_cmd[i] = CELL_HOLD;
        end
        count_next     = count_reg;
        payload_next   = payload_reg;
        valid_res_next = valid_res_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            out_valid_next = 1'b1;
            payload_next   = '0;
            valid_res_next = 1'b0;
            overflow_next  = 1'b0;
            unique case (op)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            cell_cmd[i] = CELL_SHIFT;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (load_idx == IDX_W'(i)) begin
                                cell_cmd[i] = CELL_LOAD;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_PEEK_FRONT: begin
                    if (!empty) begin
                        payload_next   = DATA_W'(cell_data[0]);
                        valid_res_next = 1'b1;
                        if (op == OP_POP_FRONT) begin
                            for (int i = 0; i < DEPTH; i++) begin
                                cell_cmd[i] = CELL_PULL;
                            end
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_POP_BACK, OP_PEEK_BACK: begin
                    if (!empty) begin
                        payload_next   = DATA_W'(rd_data);
                        valid_res_next = 1'b1;
                        if (op == OP_POP_BACK) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_NTH: begin
                    if (pos_ext < cnt_ext) begin
                        payload_next   = DATA_W'(rd_data);
                        valid_res_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Cell chain: entry i sits at logical position i from the front
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] front_nb;
        logic [WIDTH-1:0] back_nb;

        if (g == 0) begin : g_first
            assign front_nb = word;
        end else begin : g_mid_front
            assign front_nb = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign back_nb = cell_data[g];
        end else begin : g_mid_back
            assign back_nb = cell_data[g+1];
        end

        dq_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd[g]),
            .front_data (front_nb),
            .back_data  (back_nb),
            .load_data  (word),
            .data       (cell_data[g])
        );
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        payload_reg   <= payload_next;
        valid_res_reg <= valid_res_next;
        overflow_reg  <= overflow_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_payload_out = payload_reg;
    assign m_valid_res   = valid_res_reg;
    assign m_overflow    = overflow_reg;

endmodule

// File: src/dq_cell.sv
// One storage cell of the queue chain: holds the entry at a fixed logical position.
module dq_cell #(
    parameter int WIDTH = dq_pkg::WIDTH_DEF
) (
    input  logic               aclk,
    input  dq_pkg::cell_cmd_t  cmd,
    input  logic [WIDTH-1:0]   front_data,  // neighbor nearer the front
    input  logic [WIDTH-1:0]   back_data,   // neighbor nearer the back
    input  logic [WIDTH-1:0]   load_data,
    output logic [WIDTH-1:0]   data
);
    import dq_pkg::*;

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // Next entry value from the command
    always_comb begin
        unique case (cmd)
            CELL_SHIFT: data_next = front_data;
            CELL_PULL:  data_next = back_data;
            CELL_LOAD:  data_next = load_data;
            default:    data_next = data_reg;
        endcase
    end

    // Payload storage, no reset needed
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: src/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
module dq_port_props (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dq_pkg::DATA_W-1:0]     m_payload_out,
    input logic                          m_valid_res,
    input logic                          m_overflow
);
    import dq_pkg::*;

    // Every input transfer shows a result on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after input transfer");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // A dropped push returns no entry
    a_overflow_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> !m_valid_res && (m_payload_out == '0))
        else $error("overflow result carries data");

    // No entry returned means zero payload
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> (m_payload_out == '0))
        else $error("invalid result with nonzero payload");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_out))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dq_port_props u_dq_port_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_payload_out (m_payload_out),
    .m_valid_res   (m_valid_res),
    .m_overflow    (m_overflow)
);

// File: verif/dq_checker.sv
// Checker for the double-ended queue: models it as a ring store and compares every result.
module dq_checker
    import dq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OPCODE_W-1:0] s_opcode,
    input  logic [DATA_W-1:0]   s_payload_in,
    input  logic [POS_W-1:0]    s_position,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [DATA_W-1:0]   m_payload_out,
    input  logic                m_valid_res,
    input  logic                m_overflow,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int SLOTS = DEPTH_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              hit;
        logic              ovf;
    } deq_result_t;

    // Mirror of the ring: contents, front slot and live entry count
    logic [DATA_W-1:0] ring [SLOTS];
    int                front_slot;
    int                live;

    deq_result_t       due_results [$];
    deq_result_t       step_res;
    deq_result_t       want;

    function automatic int slot_at(input int off);
        return (front_slot + off) % SLOTS;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] wanted);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, wanted);
        fail_count++;
    endtask

    // Apply one operation to the mirror and return the result it should give
    task automatic deque_step(input op_t op, input logic [DATA_W-1:0] word, input int pos,
                              output deq_result_t res);
        res = '0;
        case (op)
            OP_PUSH_FRONT: begin
                if (live == SLOTS) begin
                    res.ovf = 1'b1;
                end else begin
                    front_slot = (front_slot + SLOTS - 1) % SLOTS;
                    ring[front_slot] = word;
                    live++;
                end
            end
            OP_PUSH_BACK: begin
                if (live == SLOTS) begin
                    res.ovf = 1'b1;
                end else begin
                    ring[slot_at(live)] = word;
                    live++;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (live != 0) begin
                    res.word = ring[front_slot];
                    res.hit  = 1'b1;
                    if (op == OP_POP_FRONT) begin
                        front_slot = slot_at(1);
                        live--;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (live != 0) begin
                    res.word = ring[slot_at(live - 1)];
                    res.hit  = 1'b1;
                    if (op == OP_POP_BACK) live--;
                end
            end
            OP_NTH: begin
                if (pos < live) begin
                    res.word = ring[slot_at(pos)];
                    res.hit  = 1'b1;
                end
            end
            default: ;  // unused opcode: all-zero result, state untouched
        endcase
    endtask

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            front_slot = 0;
            live       = 0;
            due_results.delete();
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready) begin
                deque_step(op_t'(s_opcode), s_payload_in, int'(s_position), step_res);
                due_results.push_back(step_res);
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing pending", m_payload_out, '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_payload_out !== want.word)
                        report_mismatch("payload_out", m_payload_out, want.word);
                    if (m_valid_res !== want.hit)
                        report_mismatch("valid_res", DATA_W'(m_valid_res), DATA_W'(want.hit));
                    if (m_overflow !== want.ovf)
                        report_mismatch("overflow", DATA_W'(m_overflow), DATA_W'(want.ovf));
                end
            end
            outstanding <= due_results.size();
        end
    end

endmodule

// File: verif/tb.sv
// Testbench top for the double-ended queue: clock, reset, stimulus, idling and verdict.
module tb;
    import dq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef enum {GROW, SHRINK, CHURN} trend_t;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode     = '0;
    logic [DATA_W-1:0]   s_payload_in = '0;
    logic [POS_W-1:0]    s_position   = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [DATA_W-1:0]   m_payload_out;
    logic                m_valid_res;
    logic                m_overflow;

    int fail_count;
    int outstanding;
    int send_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;

    double_ended_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_payload_in  (s_payload_in),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload_out (m_payload_out),
        .m_valid_res   (m_valid_res),
        .m_overflow    (m_overflow)
    );

    dq_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_payload_in  (s_payload_in),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload_out (m_payload_out),
        .m_valid_res   (m_valid_res),
        .m_overflow    (m_overflow),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: random back-pressure at the current stall rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run after too many cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One transfer on the input side, with random gaps ahead of it
    task automatic send_op(input op_t op, input logic [DATA_W-1:0] word,
                           input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_payload_in <= word;
        s_position   <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold the input side until every pending result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic op_t pick_op(input trend_t trend);
        int roll;
        roll = $urandom_range(99);
        if (trend == GROW && roll < 70) return op_t'($urandom_range(1));
        if (trend == SHRINK && roll < 70) return op_t'($urandom_range(3, 2));
        if (roll < 3) return OP_NONE;
        return op_t'($urandom_range(6));
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '1;
        if (roll < 20) return '0;
        return $urandom;
    endfunction

    // Empty reads, unused opcode, fill to full, overflow on both ends, edge positions
    task automatic run_directed();
        send_op(OP_POP_FRONT, $urandom, 4'd0);
        send_op(OP_PEEK_BACK, $urandom, 4'd0);
        send_op(OP_NTH, $urandom, 4'd0);
        send_op(OP_NONE, '1, '1);
        for (int i = 0; i < DEPTH_DEF; i++) begin
            send_op((i % 2 != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                    (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : $urandom, '1);
        end
        send_op(OP_PUSH_BACK, $urandom, 4'd0);
        send_op(OP_PUSH_FRONT, $urandom, 4'd0);
        send_op(OP_NTH, $urandom, 4'd15);
        send_op(OP_PEEK_FRONT, $urandom, 4'd0);
        send_op(OP_POP_BACK, $urandom, 4'd0);
        send_op(OP_POP_FRONT, $urandom, 4'd0);
        send_op(OP_NTH, $urandom, 4'd15);
    endtask

    // Random operations in runs that push the fill level up, down or around
    task automatic run_random(input int n_items);
        trend_t trend;
        int     run_left;
        trend    = CHURN;
        run_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                trend    = trend_t'($urandom_range(2));
                run_left = $urandom_range(40, 8);
            end
            run_left--;
            send_op(pick_op(trend), pick_word(), POS_W'($urandom_range(15)));
        end
    endtask

    initial begin
        send_gap_pct   = 25;
        recv_stall_pct = 60;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(460);
        drain_results();

        send_gap_pct   = 60;
        recv_stall_pct = 25;
        run_random(480);
        drain_results();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random(485);

        // Wait out the last results and anything stray, then give the verdict
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
